// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: segment tree range query shared definitions
// Sizes, command and operator codes, register indexes and word types.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int LEAVES    = 1024;
  localparam int SPAN_LOG  = $clog2(LEAVES);
  localparam int SPAN      = 1 << SPAN_LOG;
  localparam int NODE_AW   = SPAN_LOG + 1;
  localparam int NODES     = 2 * SPAN;
  localparam int SH_W      = $clog2(SPAN_LOG + 1);
  localparam int POS_W     = 11;
  localparam int VAL_W     = 64;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_SUM = 2'd0,
    OP_MIN = 2'd1,
    OP_MAX = 2'd2,
    OP_XOR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMBINE_OP = 1'b0,
    REG_IDENTITY   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        range_end;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    status;
  } out_word_t;

endpackage

// File: rtl/stq_combine.sv
// ----------------------------------------------------------------------------
// stq_combine: node combine unit
// Wrapping sum, signed minimum, signed maximum or xor of two node values.
// ----------------------------------------------------------------------------
module stq_combine (
  input  stq_pkg::op_t                     op,
  input  logic signed [stq_pkg::VAL_W-1:0] a,
  input  logic signed [stq_pkg::VAL_W-1:0] b,
  output logic signed [stq_pkg::VAL_W-1:0] y
);

  always_comb begin
    case (op)
      stq_pkg::OP_SUM: y = a + b;
      stq_pkg::OP_MIN: y = (a <= b) ? a : b;
      stq_pkg::OP_MAX: y = (a >= b) ? a : b;
      stq_pkg::OP_XOR: y = a ^ b;
      default:         y = a ^ b;
    endcase
  end

endmodule

// File: rtl/segment_tree_range_query.sv
// ----------------------------------------------------------------------------
// segment_tree_range_query: segment tree with point update and range query
// Heap-ordered node memory walked by a small sequencer around one combine unit.
// ----------------------------------------------------------------------------
//  channel  | ports                           | handshake
//  ---------+---------------------------------+------------------------------
//  input    | start, busy, in_word            | taken when start & !busy
//  result   | out_valid, out_word             | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data     | write when cfg_we
//
//  Busy after the accepting edge: set walks from the leaf to the root, one
//  level per cycle, and add first reads the leaf; query visits four child
//  slots per level, one child slot per cycle, then drains, while a whole-tree
//  query reads the root alone; bad positions and empty ranges answer right
//  after the accepting edge with no busy cycle. Clear writes every node. After
//  reset a clearing pass zeroes the nodes; busy is high meanwhile. Results cannot be held off.
// ----------------------------------------------------------------------------
module segment_tree_range_query (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  stq_pkg::in_word_t                    in_word,
  output logic                                 out_valid,
  output stq_pkg::out_word_t                   out_word,
  input  logic                                 cfg_we,
  input  logic [stq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stq_pkg::VAL_W-1:0]            cfg_data
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_UADD,
    ST_UUP,
    ST_QWALK,
    ST_QDRAIN
  } state_t;

  localparam int AW = stq_pkg::NODE_AW;
  localparam int LW = stq_pkg::SPAN_LOG;
  localparam int SW = stq_pkg::SH_W;
  localparam int VW = stq_pkg::VAL_W;
  localparam int PW = stq_pkg::POS_W;

  // config registers
  stq_pkg::op_t         combine_op_r;
  logic signed [VW-1:0] identity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      combine_op_r <= stq_pkg::OP_SUM;
      identity_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        stq_pkg::REG_COMBINE_OP: combine_op_r <= stq_pkg::op_t'(cfg_data[1:0]);
        stq_pkg::REG_IDENTITY:   identity_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // node memory
  logic [VW-1:0]        tree_mem [stq_pkg::NODES];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic signed [VW-1:0] mem_wdata;
  logic signed [VW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) tree_mem[mem_waddr] <= mem_wdata;
    rdata_r <= tree_mem[mem_raddr];
  end

  // sequencer registers
  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic                 sweep_cmd_r, sweep_cmd_nxt;
  logic signed [VW-1:0] fill_r, fill_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic signed [VW-1:0] cur_r, cur_nxt;
  logic signed [VW-1:0] res_r, res_nxt;
  logic signed [VW-1:0] acc_r, acc_nxt;
  logic                 acc_ok_r, acc_ok_nxt;
  logic                 pend_mem_r, pend_mem_nxt;
  logic                 pend_id_r, pend_id_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [LW-1:0]        lz_r, lz_nxt;
  logic [LW-1:0]        rz_r, rz_nxt;
  logic [SW-1:0]        lvl_r, lvl_nxt;
  logic [1:0]           slot_r, slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stq_pkg::out_word_t   out_word_r, out_word_nxt;

  // shared combine unit
  stq_pkg::op_t         alu_op;
  logic signed [VW-1:0] alu_a;
  logic signed [VW-1:0] alu_b;
  logic signed [VW-1:0] alu_y;

  stq_combine u_combine (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // input decode
  logic          accept;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] end_m1;
  logic [LW-1:0] lz_in;
  logic [LW-1:0] rz_in;
  logic          pos_ok;
  logic          end_ok;
  logic [AW-1:0] leaf_in;

  assign accept  = start && (state_r == ST_IDLE);
  assign pos_m1  = in_word.position - PW'(1);
  assign end_m1  = in_word.range_end - PW'(1);
  assign lz_in   = pos_m1[LW-1:0];
  assign rz_in   = end_m1[LW-1:0];
  assign pos_ok  = (in_word.position != '0) && (in_word.position <= PW'(stq_pkg::LEAVES));
  assign end_ok  = (in_word.range_end != '0) && (in_word.range_end <= PW'(stq_pkg::LEAVES));
  assign leaf_in = {1'b1, lz_in};

  // query slot decode: parent is the level ancestor of the left or right end
  logic [SW-1:0] sh;
  logic [SW-1:0] csh;
  logic [AW-1:0] pm_wide;
  logic [LW-1:0] pmask;
  logic [LW-1:0] cmask;
  logic [LW-1:0] cbit;
  logic [LW-1:0] base;
  logic [LW-1:0] plo;
  logic [LW-1:0] phi;
  logic [LW-1:0] clo;
  logic [LW-1:0] chi;
  logic          par_full;
  logic          dup;
  logic          live;
  logic          c_full;
  logic          c_dis;
  logic [AW-1:0] cnode;
  logic          last_slot;
  logic [AW-1:0] parent;

  always_comb begin
    sh        = SW'(LW) - lvl_r;
    csh       = sh - SW'(1);
    pm_wide   = (AW'(1) << sh) - AW'(1);
    pmask     = pm_wide[LW-1:0];
    cmask     = pmask >> 1;
    cbit      = pmask ^ cmask;
    base      = slot_r[1] ? rz_r : lz_r;
    plo       = base & ~pmask;
    phi       = plo | pmask;
    par_full  = (plo >= lz_r) && (phi <= rz_r);
    dup       = slot_r[1] && ((rz_r & ~pmask) == (lz_r & ~pmask));
    live      = !par_full && !dup;
    clo       = plo | (slot_r[0] ? cbit : '0);
    chi       = clo | cmask;
    c_full    = (clo >= lz_r) && (chi <= rz_r);
    c_dis     = (clo > rz_r) || (chi < lz_r);
    cnode     = {1'b1, clo} >> csh;
    last_slot = (lvl_r == SW'(LW - 1)) && (slot_r == 2'd3);
    parent    = idx_r >> 1;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sweep_cmd_nxt = sweep_cmd_r;
    fill_nxt      = fill_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    acc_nxt       = acc_r;
    acc_ok_nxt    = acc_ok_r;
    pend_mem_nxt  = 1'b0;
    pend_id_nxt   = 1'b0;
    idx_nxt       = idx_r;
    lz_nxt        = lz_r;
    rz_nxt        = rz_r;
    lvl_nxt       = lvl_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = alu_y;
    mem_raddr     = idx_r;
    alu_op        = combine_op_r;
    alu_a         = acc_r;
    alu_b         = pend_mem_r ? rdata_r : identity_r;

    // pending query contribution from the previous slot
    if (pend_mem_r || pend_id_r) begin
      acc_nxt    = acc_ok_r ? alu_y : alu_b;
      acc_ok_nxt = 1'b1;
    end

    case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = fill_r;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(stq_pkg::NODES - 1)) begin
          state_nxt     = ST_IDLE;
          sweep_cmd_nxt = 1'b0;
          if (sweep_cmd_r) begin
            out_valid_nxt             = 1'b1;
            out_word_nxt.result_value = fill_r;
            out_word_nxt.status       = 1'b0;
          end
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (in_word.command)
            stq_pkg::CMD_CLEAR: begin
              fill_nxt      = identity_r;
              cnt_nxt       = '0;
              sweep_cmd_nxt = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            stq_pkg::CMD_SET: begin
              if (!pos_ok) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.result_value = '0;
                out_word_nxt.status       = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = leaf_in;
                mem_wdata = in_word.value;
                mem_raddr = leaf_in ^ AW'(1);
                cur_nxt   = in_word.value;
                res_nxt   = in_word.value;
                idx_nxt   = leaf_in;
                state_nxt = ST_UUP;
              end
            end
            stq_pkg::CMD_ADD: begin
              if (!pos_ok) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.result_value = '0;
                out_word_nxt.status       = 1'b1;
              end else begin
                mem_raddr = leaf_in;
                val_nxt   = in_word.value;
                idx_nxt   = leaf_in;
                state_nxt = ST_UADD;
              end
            end
            stq_pkg::CMD_QUERY: begin
              if (!pos_ok || !end_ok) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.result_value = '0;
                out_word_nxt.status       = 1'b1;
              end else if (in_word.position > in_word.range_end) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.result_value = identity_r;
                out_word_nxt.status       = 1'b0;
              end else begin
                lz_nxt     = lz_in;
                rz_nxt     = rz_in;
                lvl_nxt    = '0;
                slot_nxt   = '0;
                acc_ok_nxt = 1'b0;
                if ((lz_in == '0) && (rz_in == LW'(stq_pkg::SPAN - 1))) begin
                  // whole tree: root alone
                  mem_raddr    = AW'(1);
                  pend_mem_nxt = 1'b1;
                  state_nxt    = ST_QDRAIN;
                end else begin
                  state_nxt = ST_QWALK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_UADD: begin
        alu_op    = stq_pkg::OP_SUM;
        alu_a     = rdata_r;
        alu_b     = val_r;
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = alu_y;
        mem_raddr = idx_r ^ AW'(1);
        cur_nxt   = alu_y;
        res_nxt   = alu_y;
        state_nxt = ST_UUP;
      end

      ST_UUP: begin
        alu_op    = combine_op_r;
        alu_a     = idx_r[0] ? rdata_r : cur_r;
        alu_b     = idx_r[0] ? cur_r : rdata_r;
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = alu_y;
        mem_raddr = parent ^ AW'(1);
        cur_nxt   = alu_y;
        idx_nxt   = parent;
        if (parent == AW'(1)) begin
          state_nxt                 = ST_IDLE;
          out_valid_nxt             = 1'b1;
          out_word_nxt.result_value = res_r;
          out_word_nxt.status       = 1'b0;
        end
      end

      ST_QWALK: begin
        mem_raddr    = cnode;
        pend_mem_nxt = live && c_full;
        pend_id_nxt  = live && c_dis;
        slot_nxt     = slot_r + 2'd1;
        if (slot_r == 2'd3) lvl_nxt = lvl_r + SW'(1);
        if (last_slot) state_nxt = ST_QDRAIN;
      end

      ST_QDRAIN: begin
        state_nxt                 = ST_IDLE;
        out_valid_nxt             = 1'b1;
        out_word_nxt.result_value = acc_nxt;
        out_word_nxt.status       = 1'b0;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cnt_r       <= '0;
      sweep_cmd_r <= 1'b0;
      fill_r      <= '0;
      pend_mem_r  <= 1'b0;
      pend_id_r   <= 1'b0;
      acc_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_cmd_r <= sweep_cmd_nxt;
      fill_r      <= fill_nxt;
      pend_mem_r  <= pend_mem_nxt;
      pend_id_r   <= pend_id_nxt;
      acc_ok_r    <= acc_ok_nxt;
      out_valid_r <= out_valid_nxt;
      val_r       <= val_nxt;
      cur_r       <= cur_nxt;
      res_r       <= res_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      lz_r        <= lz_nxt;
      rz_r        <= rz_nxt;
      lvl_r       <= lvl_nxt;
      slot_r      <= slot_nxt;
      out_word_r  <= out_word_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: bench/tb_segment_tree_range_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_tree_range_query: self-checking bench for the segment tree block
// A queue of pending commands and register writes feeds a clocked driver that
// predicts every accepted word on a local copy of the tree; a clocked monitor
// compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_segment_tree_range_query;
  import stq_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [63:0] V_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] V_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ENT_WORD,
    ENT_CFG,
    ENT_IDLE,
    ENT_DRAIN
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    in_word_t    word;
    cfg_reg_t    idx;
    logic [63:0] data;
  } pending_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       out_valid;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  pending_t   cmd_queue[$];
  out_word_t  pending_results[$];
  logic [4:0] hold_cnt = '0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  logic       burst = 1'b0;
  int         win_lo = 1;
  int         win_hi = LEAVES;

  logic [63:0] seg_nodes [0:NODES-1] = '{default: '0};
  op_t         mdl_op = OP_SUM;
  logic [63:0] mdl_identity = '0;

  segment_tree_range_query u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] combine_nodes(logic [63:0] a, logic [63:0] b);
    case (mdl_op)
      OP_SUM:  return a + b;
      OP_MIN:  return ($signed(a) <= $signed(b)) ? a : b;
      OP_MAX:  return ($signed(a) >= $signed(b)) ? a : b;
      default: return a ^ b;
    endcase
  endfunction

  // all operators are associative and commutative, so the pieces of the
  // recursive split can be folded in any order
  function automatic logic [63:0] range_combine(int l, int r);
    int lo_s [0:63];
    int hi_s [0:63];
    int ix_s [0:63];
    int sp;
    int lo;
    int hi;
    int ix;
    int mid;
    logic [63:0] acc;
    logic [63:0] part;
    logic have;
    logic done;
    sp = 1;
    lo_s[0] = 1;
    hi_s[0] = SPAN;
    ix_s[0] = 1;
    acc = '0;
    have = 1'b0;
    while (sp != 0) begin
      sp = sp - 1;
      lo = lo_s[sp];
      hi = hi_s[sp];
      ix = ix_s[sp];
      done = 1'b1;
      if (lo >= l && hi <= r) begin
        part = seg_nodes[ix];
      end else if (lo > r || hi < l) begin
        part = mdl_identity;
      end else begin
        mid = (lo + hi) >> 1;
        lo_s[sp] = lo;
        hi_s[sp] = mid;
        ix_s[sp] = 2 * ix;
        lo_s[sp + 1] = mid + 1;
        hi_s[sp + 1] = hi;
        ix_s[sp + 1] = 2 * ix + 1;
        sp = sp + 2;
        done = 1'b0;
      end
      if (done) begin
        acc = have ? combine_nodes(acc, part) : part;
        have = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic out_word_t tree_apply(in_word_t w);
    out_word_t res;
    int p;
    int e;
    int ix;
    res.result_value = '0;
    res.status = 1'b0;
    p = int'(w.position);
    e = int'(w.range_end);
    case (cmd_t'(w.command))
      CMD_CLEAR: begin
        for (ix = 0; ix < NODES; ix++) seg_nodes[ix] = mdl_identity;
        res.result_value = mdl_identity;
      end
      CMD_SET, CMD_ADD: begin
        if (p < 1 || p > LEAVES) begin
          res.status = 1'b1;
        end else begin
          ix = SPAN + p - 1;
          if (cmd_t'(w.command) == CMD_SET) seg_nodes[ix] = w.value;
          else seg_nodes[ix] = seg_nodes[ix] + w.value;
          res.result_value = seg_nodes[ix];
          for (ix = ix >> 1; ix != 0; ix = ix >> 1)
            seg_nodes[ix] = combine_nodes(seg_nodes[2 * ix], seg_nodes[2 * ix + 1]);
        end
      end
      default: begin
        if (p < 1 || p > LEAVES || e < 1 || e > LEAVES) res.status = 1'b1;
        else if (p > e) res.result_value = mdl_identity;
        else res.result_value = range_combine(p, e);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : drive_proc
    logic sending;
    logic we_next;
    pending_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      hold_cnt <= '0;
    end else begin
      sending = start;
      we_next = 1'b0;
      if (start && !busy) begin
        pending_results.push_back(tree_apply(in_word));
        sending = 1'b0;
      end
      if (!sending) begin
        if (hold_cnt != 0) begin
          hold_cnt <= hold_cnt - 5'd1;
        end else if (cmd_queue.size() != 0) begin
          head = cmd_queue[0];
          case (head.kind)
            ENT_IDLE: begin
              hold_cnt <= head.data[4:0] - 5'd1;
              head = cmd_queue.pop_front();
            end
            ENT_WORD: begin
              in_word <= head.word;
              sending = 1'b1;
              head = cmd_queue.pop_front();
            end
            ENT_CFG: begin
              if (pending_results.size() == 0 && !busy) begin
                we_next = 1'b1;
                cfg_index <= head.idx;
                cfg_data <= head.data;
                if (head.idx == REG_COMBINE_OP) mdl_op = op_t'(head.data[1:0]);
                else mdl_identity = head.data;
                head = cmd_queue.pop_front();
              end
            end
            default: begin
              if (pending_results.size() == 0 && !busy) head = cmd_queue.pop_front();
            end
          endcase
        end
      end
      start <= sending;
      cfg_we <= we_next;
    end
  end

  always @(posedge clk) begin : check_proc
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected word: value %h status %b", out_word.result_value,
                   out_word.status);
      end else begin
        want = pending_results.pop_front();
        if (out_word.result_value !== want.result_value || out_word.status !== want.status) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("bad word: expected value %h status %b, got value %h status %b",
                     want.result_value, want.status, out_word.result_value,
                     out_word.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("segment_tree_range_query: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(cmd_t c, int p, int e, logic [63:0] v);
    pending_t ent;
    int g;
    g = burst ? 0 : $urandom_range(0, 18);
    if (g != 0) begin
      ent = '0;
      ent.kind = ENT_IDLE;
      ent.data = 64'(g);
      cmd_queue.push_back(ent);
    end
    ent = '0;
    ent.kind = ENT_WORD;
    ent.word.command = c;
    ent.word.position = p[POS_W-1:0];
    ent.word.range_end = e[POS_W-1:0];
    ent.word.value = v;
    cmd_queue.push_back(ent);
  endtask

  task automatic push_cfg(cfg_reg_t idx, logic [63:0] d);
    pending_t ent;
    ent = '0;
    ent.kind = ENT_CFG;
    ent.idx = idx;
    ent.data = d;
    cmd_queue.push_back(ent);
  endtask

  task automatic push_drain();
    pending_t ent;
    ent = '0;
    ent.kind = ENT_DRAIN;
    cmd_queue.push_back(ent);
  endtask

  function automatic logic [63:0] pick_value();
    int r;
    int s;
    logic [15:0] h;
    r = $urandom_range(0, 99);
    if (r < 40) return {$urandom, $urandom};
    if (r < 70) begin
      s = $urandom_range(0, 200);
      s = s - 100;
      return {{32{s[31]}}, s};
    end
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return V_MIN;
        1: return V_MAX;
        2: return '1;
        default: return '0;
      endcase
    end
    h = 16'($urandom);
    return {{48{h[15]}}, h};
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 6) return $urandom_range(LEAVES + 1, 2047);
    if (r < 8) return win_lo;
    if (r < 10) return win_hi;
    return $urandom_range(win_lo, win_hi);
  endfunction

  task automatic push_random_cmd();
    int r;
    int a;
    int b;
    int t;
    r = $urandom_range(0, 199);
    if (r < 2) begin
      push_cmd(CMD_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047), pick_value());
    end else if (r < 70) begin
      push_cmd(CMD_SET, pick_pos(), $urandom_range(0, 2047), pick_value());
    end else if (r < 110) begin
      push_cmd(CMD_ADD, pick_pos(), $urandom_range(0, 2047), pick_value());
    end else begin
      a = pick_pos();
      b = pick_pos();
      if ($urandom_range(0, 9) != 0 && a > b) begin
        t = a;
        a = b;
        b = t;
      end
      push_cmd(CMD_QUERY, a, b, {$urandom, $urandom});
    end
  endtask

  task automatic run_phase(op_t op, logic [63:0] ident, int n);
    logic [63:0] d;
    int k;
    push_drain();
    d = {$urandom, $urandom};
    d[1:0] = op;
    push_cfg(REG_COMBINE_OP, d);
    push_cfg(REG_IDENTITY, ident);
    if ($urandom_range(0, 3) != 0) push_cmd(CMD_CLEAR, 0, 0, pick_value());
    case ($urandom_range(0, 2))
      0: begin
        win_lo = 1;
        win_hi = LEAVES;
      end
      1: begin
        win_lo = $urandom_range(1, LEAVES - 15);
        win_hi = win_lo + 15;
      end
      default: begin
        win_lo = $urandom_range(0, 1) ? 1 : LEAVES - 63;
        win_hi = win_lo + 63;
      end
    endcase
    for (k = 0; k < n; k++) begin
      if (k % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k % 97 == 96) push_drain();
      push_random_cmd();
    end
  endtask

  initial begin : stim_proc
    burst = 1'b0;
    push_cmd(CMD_QUERY, 1, LEAVES, '0);
    push_cfg(REG_COMBINE_OP, 64'(OP_SUM));
    push_cfg(REG_IDENTITY, '0);
    push_cmd(CMD_SET, 1, 2047, V_MAX);
    push_cmd(CMD_SET, LEAVES, 0, V_MIN);
    push_cmd(CMD_ADD, 1, 0, 64'd1);
    push_cmd(CMD_ADD, 512, 0, '1);
    push_cmd(CMD_QUERY, 1, LEAVES, '1);
    push_cmd(CMD_QUERY, 1, 1, '0);
    push_cmd(CMD_QUERY, LEAVES, LEAVES, '0);
    push_cmd(CMD_QUERY, 2, LEAVES - 1, '0);
    push_cmd(CMD_QUERY, 9, 3, '0);
    push_cmd(CMD_SET, 0, 5, V_MAX);
    push_cmd(CMD_ADD, LEAVES + 1, 5, 64'd1);
    push_cmd(CMD_SET, 2047, 2047, '1);
    push_cmd(CMD_QUERY, 0, 5, '0);
    push_cmd(CMD_QUERY, 5, 2047, '0);
    push_cmd(CMD_QUERY, 2047, 0, '0);
    push_drain();
    push_cfg(REG_COMBINE_OP, 64'(OP_MIN));
    push_cfg(REG_IDENTITY, V_MAX);
    push_cmd(CMD_CLEAR, 0, 0, '0);
    push_cmd(CMD_SET, 3, 0, -64'sd5);
    push_cmd(CMD_SET, 700, 0, 64'd9);
    push_cmd(CMD_QUERY, 1, LEAVES, '0);
    push_cmd(CMD_QUERY, 4, 699, '0);
    // operator change leaves stored nodes as they are
    push_cfg(REG_COMBINE_OP, 64'(OP_MAX));
    push_cfg(REG_IDENTITY, V_MIN);
    push_cmd(CMD_QUERY, 1, LEAVES, '0);
    push_cmd(CMD_SET, 10, 0, 64'd42);
    push_cmd(CMD_QUERY, 1, 20, '0);
    push_cfg(REG_COMBINE_OP, 64'(OP_XOR));
    push_cfg(REG_IDENTITY, {$urandom, $urandom});
    push_cmd(CMD_QUERY, 100, 200, '0);

    run_phase(OP_SUM, '0, 250);
    run_phase(OP_MIN, V_MAX, 250);
    run_phase(OP_MAX, V_MIN, 250);
    run_phase(OP_XOR, '0, 250);
    run_phase(OP_SUM, {$urandom, $urandom}, 240);
    run_phase(OP_MIN, {$urandom, $urandom}, 240);
    run_phase(OP_MAX, '1, 240);
    run_phase(OP_XOR, {$urandom, $urandom}, 240);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || start || busy || pending_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("segment_tree_range_query: match");
    end else begin
      $display("segment_tree_range_query: mismatch");
    end
    $finish;
  end

endmodule
